[hw/rtl/esmc_pkg.sv]
// Types, codes and helper functions shared by the encoder stepper motor controller.
`default_nettype none
package esmc_pkg;

  localparam int KNOB_MAX    = 9;
  localparam int FAST_STEP   = 10;
  localparam int PHASE_COUNT = 4;
  localparam int SHOW_WIDTH  = 16;

  typedef enum logic [1:0] {
    KIND_ENCODER = 2'd0,
    KIND_BUTTONS = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_ENCODER = 4'b0001,
    OP_BUTTONS = 4'b0010,
    OP_TICK    = 4'b0100,
    OP_IGNORE  = 4'b1000
  } op_t;

  typedef enum logic [1:0] {
    MODE_FOLLOW  = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_STOPPED = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       clk_level;
    logic       dt_level;
    logic       switch_pressed;
    logic [3:0] buttons;
  } item_t;

  typedef struct packed {
    op_t        op;
    logic       clk_level;
    logic       dt_level;
    logic       switch_pressed;
    logic [3:0] buttons;
  } cmd_t;

  typedef struct packed {
    logic [3:0]            coils;
    logic [SHOW_WIDTH-1:0] shown_value;
    logic [1:0]            mode;
    logic [SHOW_WIDTH-1:0] position;
  } result_t;

  function automatic logic [2:0] phase_forward(input logic [2:0] p);
    return (p >= 3'(PHASE_COUNT)) ? 3'd1 : p + 3'd1;
  endfunction

  function automatic logic [2:0] phase_back(input logic [2:0] p);
    return (p <= 3'd1 || p > 3'(PHASE_COUNT)) ? 3'(PHASE_COUNT) : p - 3'd1;
  endfunction

  function automatic logic phase_drives(input logic [2:0] p);
    return (p >= 3'd1) && (p <= 3'(PHASE_COUNT));
  endfunction

  function automatic logic [3:0] phase_coil(input logic [2:0] p);
    return 4'(4'b0001 << (p - 3'd1));
  endfunction

endpackage
`default_nettype wire

[hw/rtl/esmc_queue.sv]
// Two-entry word queue with registered head and tail slots.
`default_nettype none
module esmc_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_word,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      head_word
);

  logic             head_valid;
  logic             tail_valid;
  logic [WIDTH-1:0] head;
  logic [WIDTH-1:0] tail;
  logic             do_push;
  logic             do_pop;

  assign full      = tail_valid;
  assign empty     = !head_valid;
  assign head_word = head;
  assign do_push   = push && !tail_valid;
  assign do_pop    = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (do_pop) begin
      head_valid <= tail_valid || do_push;
      tail_valid <= 1'b0;
    end else if (do_push) begin
      if (head_valid) begin
        tail_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      head <= tail_valid ? tail : push_word;
    end else if (do_push) begin
      if (head_valid) begin
        tail <= push_word;
      end else begin
        head <= push_word;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/esmc_front.sv]
// Front end: accepts event words and classifies them into commands.
`default_nettype none
module esmc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire esmc_pkg::item_t item,
  output logic                full,
  output logic                cmd_valid,
  output esmc_pkg::cmd_t      cmd,
  input  wire logic           cmd_full
);
  import esmc_pkg::*;

  logic  valid;
  cmd_t  held;
  op_t   op_next;
  logic  take;

  always_comb begin
    unique case (kind_t'(item.kind))
      KIND_ENCODER: op_next = OP_ENCODER;
      KIND_BUTTONS: op_next = OP_BUTTONS;
      KIND_TICK:    op_next = OP_TICK;
      default:      op_next = OP_IGNORE;
    endcase
  end

  assign full      = valid && cmd_full;
  assign take      = push && !full;
  assign cmd_valid = valid;
  assign cmd       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (!cmd_full) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held.op             <= op_next;
      held.clk_level      <= item.clk_level;
      held.dt_level       <= item.dt_level;
      held.switch_pressed <= item.switch_pressed;
      held.buttons        <= item.buttons;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/esmc_back.sv]
// Back end: carries out commands on the controller state and emits result words.
`default_nettype none
module esmc_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  input  wire esmc_pkg::cmd_t   cmd,
  output logic                  cmd_pop,
  output logic                  res_push,
  output esmc_pkg::result_t     res,
  input  wire logic             res_full
);
  import esmc_pkg::*;

  localparam int CW = COUNT_WIDTH;

  mode_t         run_mode,   run_mode_next;
  logic [CW-1:0] knob_value, knob_value_next;
  logic [CW-1:0] goal,       goal_next;
  logic [CW-1:0] step_count, step_count_next;
  logic [2:0]    phase,      phase_next;
  logic          last_clock, last_clock_next;
  logic [3:0]    wait_count, wait_count_next;
  logic [3:0]    coil_hold,  coil_hold_next;

  logic          fire;
  logic [CW-1:0] knob_delta;
  logic [CW-1:0] knob_moved;
  logic [2:0]    phase_new;
  logic [31:0]   knob_wide;
  logic [31:0]   step_wide;

  assign fire     = cmd_valid && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  always_comb begin
    run_mode_next   = run_mode;
    knob_value_next = knob_value;
    goal_next       = goal;
    step_count_next = step_count;
    phase_next      = phase;
    last_clock_next = last_clock;
    wait_count_next = wait_count;
    coil_hold_next  = coil_hold;
    phase_new       = phase;
    knob_delta = (cmd.switch_pressed && run_mode == MODE_FOLLOW) ? CW'(FAST_STEP) : CW'(1);
    knob_moved = cmd.dt_level ? knob_value - knob_delta : knob_value + knob_delta;

    unique case (cmd.op)
      OP_ENCODER: begin
        if (cmd.clk_level != last_clock) begin
          if (!cmd.clk_level) begin
            knob_value_next = knob_moved;
            goal_next       = knob_moved;
          end else begin
            goal_next = knob_value;
          end
        end
        if (run_mode == MODE_FORWARD || run_mode == MODE_REVERSE) begin
          if ($signed(knob_value_next) > $signed(CW'(KNOB_MAX))) begin
            knob_value_next = CW'(KNOB_MAX);
          end else if (knob_value_next[CW-1]) begin
            knob_value_next = '0;
          end
        end
        last_clock_next = cmd.clk_level;
      end
      OP_BUTTONS: begin
        if (cmd.buttons[0]) begin
          step_count_next = '0;
          goal_next       = '0;
        end
        if (cmd.buttons[2:0] != 3'b000) begin
          knob_value_next = '0;
        end
        priority if (cmd.buttons[3]) begin
          run_mode_next = MODE_STOPPED;
        end else if (cmd.buttons[2]) begin
          run_mode_next = MODE_REVERSE;
        end else if (cmd.buttons[1]) begin
          run_mode_next = MODE_FORWARD;
        end else if (cmd.buttons[0]) begin
          run_mode_next = MODE_FOLLOW;
        end
        wait_count_next = '0;
      end
      OP_TICK: begin
        unique case (run_mode)
          MODE_FOLLOW: begin
            if ($signed(goal) > $signed(step_count)) begin
              step_count_next = step_count + CW'(1);
              phase_new       = phase_forward(phase);
              phase_next      = phase_new;
              coil_hold_next  = phase_coil(phase_new);
            end else if ($signed(goal) < $signed(step_count)) begin
              step_count_next = step_count - CW'(1);
              phase_new       = phase_back(phase);
              phase_next      = phase_new;
              coil_hold_next  = phase_coil(phase_new);
            end
          end
          MODE_FORWARD, MODE_REVERSE: begin
            if (wait_count == 4'd0) begin
              if (phase_drives(phase)) begin
                coil_hold_next = phase_coil(phase);
              end
              phase_next = (run_mode == MODE_FORWARD) ? phase_forward(phase)
                                                      : phase_back(phase);
              if ($signed(knob_value) > $signed(CW'(KNOB_MAX))) begin
                wait_count_next = 4'd0;
              end else if (knob_value[CW-1]) begin
                wait_count_next = 4'(KNOB_MAX);
              end else begin
                wait_count_next = 4'(KNOB_MAX) - knob_value[3:0];
              end
            end else begin
              wait_count_next = wait_count - 4'd1;
            end
          end
          default: begin
            knob_value_next = '0;
            coil_hold_next  = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode   <= MODE_FOLLOW;
      knob_value <= '0;
      goal       <= '0;
      step_count <= '0;
      phase      <= '0;
      last_clock <= 1'b1;
      wait_count <= '0;
      coil_hold  <= '0;
    end else if (fire) begin
      run_mode   <= run_mode_next;
      knob_value <= knob_value_next;
      goal       <= goal_next;
      step_count <= step_count_next;
      phase      <= phase_next;
      last_clock <= last_clock_next;
      wait_count <= wait_count_next;
      coil_hold  <= coil_hold_next;
    end
  end

  assign knob_wide = 32'(knob_value_next);
  assign step_wide = 32'(step_count_next);

  assign res.coils       = coil_hold_next;
  assign res.shown_value = knob_wide[SHOW_WIDTH-1:0];
  assign res.mode        = run_mode_next;
  assign res.position    = step_wide[SHOW_WIDTH-1:0];

endmodule
`default_nettype wire

[hw/rtl/encoder_stepper_motor_controller.sv]
// Top level of the rotary encoder stepper motor controller.
// Event words (encoder pin sample, button sample, tick) enter through a
// push/full port and each yields exactly one result word (coil drive, knob
// value, mode, step position) on an empty/pop port, in order. One event is
// taken every clock cycle when results are popped as fast; the rate is set by
// the back end, which updates all controller state from each command it pops.
// An event passes through a classify register, a two-word command queue and a
// two-word result queue, so either side may stall without losing words. Knob,
// goal and step count are COUNT_WIDTH bits wide and wrap, but the knob is
// clamped to 0..KNOB_MAX on encoder events in the forward and reverse modes;
// the result shows the low 16 bits of the knob and the step count.
`default_nettype none
module encoder_stepper_motor_controller #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire esmc_pkg::item_t   item,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output esmc_pkg::result_t      result
);
  import esmc_pkg::*;

  logic    front_valid;
  cmd_t    front_cmd;
  logic    cmd_full;
  logic    cmd_empty;
  logic [$bits(cmd_t)-1:0] cmd_word;
  cmd_t    cmd_head;
  logic    cmd_pop;
  logic    res_push;
  result_t res_word;
  logic    res_full;
  logic [$bits(result_t)-1:0] res_head;

  esmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_full  (cmd_full)
  );

  esmc_queue #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_word (front_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .head_word (cmd_word)
  );

  assign cmd_head = cmd_t'(cmd_word);

  esmc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_word),
    .res_full  (res_full)
  );

  esmc_queue #(
    .WIDTH ($bits(result_t))
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_word (res_word),
    .full      (res_full),
    .pop       (pop),
    .empty     (empty),
    .head_word (res_head)
  );

  assign result = result_t'(res_head);

endmodule
`default_nettype wire
